// File: rtl/pwli_pkg.sv
// ----------------------------------------------------------------------------
// pwli_pkg: shared types and constants for the interpolation table
// Word formats, function codes, register indexes, border modes, status codes and FSM states.
// ----------------------------------------------------------------------------
package pwli_pkg;

	// Input word: a knot load or a query.
	typedef struct packed {
		logic               func;
		logic [7:0]         knot_index;
		logic signed [31:0] knot_coord;
		logic signed [31:0] knot_value;
		logic signed [31:0] query_x;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
	} out_word_t;

	// Function codes.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Register indexes.
	localparam logic REG_BORDER_MODE = 1'b0;
	localparam logic REG_KNOT_COUNT  = 1'b1;

	// Border modes.
	localparam logic [1:0] BORDER_ZERO   = 2'd0;
	localparam logic [1:0] BORDER_CLAMP  = 2'd1;
	localparam logic [1:0] BORDER_EXTRAP = 2'd2;
	localparam logic [1:0] BORDER_ERROR  = 2'd3;

	// Status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENDS0,
		ST_ENDS1,
		ST_DECIDE,
		ST_SCAN,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/pwli_ram.sv
// ----------------------------------------------------------------------------
// pwli_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pwli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: knot table with linear interpolation
// Loads knots into two RAMs and answers queries by interpolating between
// the enclosing knots, with a configurable behavior outside the table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid / in_ready    in_word  (pwli_pkg::in_word_t)
//  out       output     out_valid / out_ready  out_word (pwli_pkg::out_word_t)
//  cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// A load word goes from idle straight to the done state. A query that
// interpolates reads both end knots, scans for the enclosing segment, reads
// the two segment knots through the single read port of the knot RAMs, and
// then runs the multiply and the 65-step divide; extrapolation skips the scan.
// A zero-width segment skips the arithmetic; a query outside the table in the
// zero, clamp or error mode also skips the scan and the segment reads.
// Reset clears the state, the configuration registers and out_valid; the RAMs hold nothing until loaded.
// One word is worked at a time; the output register lets a new word be taken
// while a finished result waits for out_ready.
module piecewise_linear_interpolator #(
	parameter int MAX_KNOTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pwli_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pwli_pkg::out_word_t  out_word,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [8:0]           cfg_wdata
);

	localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int CW = $clog2(MAX_KNOTS + 1);

	pwli_pkg::state_t state_q, state_d;

	logic [1:0]  border_mode_q;
	logic [8:0]  knot_count_q;

	logic [31:0] rd_coord, rd_value;
	logic [AW-1:0] raddr;
	logic          ram_we;
	logic          in_acc;
	logic          out_free;

	logic signed [31:0] x_q, first_q, last_q, vfirst_q, vlast_q;
	logic signed [31:0] c0_q, c1_q, v0_q, v1_q;
	logic [AW-1:0]  idx_q, seg_q;
	logic [32:0]    ma_q, mb_q, md_q;
	logic           neg_q;
	logic [2:0]     mstep_q;
	logic [33:0]    pp_q;
	logic [5:0]     sh_q;
	logic [65:0]    acc_q;
	logic [64:0]    dvd_q;
	logic [33:0]    rem_q;
	logic [6:0]     dcnt_q;
	logic signed [31:0] res_q;
	logic [1:0]     st_q;
	logic           out_valid_q;
	pwli_pkg::out_word_t out_q;

	logic [31:0]    cnt32, n32;
	logic [CW-1:0]  n_eff;
	logic [AW-1:0]  last_addr, seg_last;
	logic           below, above;
	logic           scan_hit, scan_end;
	logic signed [32:0] dc, dx, dv;
	logic [16:0]    pa, pb;
	logic [65:0]    acc_sum;
	logic [33:0]    rem_sh;
	logic           rem_ge;
	logic           q_big;
	logic signed [34:0] s_sum;

	// Effective knot count, clamped to the table.
	always_comb begin
		cnt32 = 32'(knot_count_q);
		if (cnt32 < 32'd2) begin
			n32 = 32'd2;
		end else if (cnt32 > 32'(MAX_KNOTS)) begin
			n32 = 32'(MAX_KNOTS);
		end else begin
			n32 = cnt32;
		end
		n_eff     = CW'(n32);
		last_addr = AW'(n_eff - CW'(1));
		seg_last  = AW'(n_eff - CW'(2));
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_mode_q <= pwli_pkg::BORDER_ZERO;
			knot_count_q  <= 9'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				pwli_pkg::REG_BORDER_MODE: border_mode_q <= cfg_wdata[1:0];
				pwli_pkg::REG_KNOT_COUNT:  knot_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ram_we   = in_acc && (in_word.func == pwli_pkg::FUNC_LOAD) &&
		(32'(in_word.knot_index) < 32'(MAX_KNOTS));

	pwli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_coord_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_word.knot_index)),
		.wdata (in_word.knot_coord),
		.raddr (raddr),
		.rdata (rd_coord)
	);

	pwli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_word.knot_index)),
		.wdata (in_word.knot_value),
		.raddr (raddr),
		.rdata (rd_value)
	);

	// Datapath conditions.
	always_comb begin
		below    = x_q < first_q;
		above    = x_q > last_q;
		scan_hit = x_q < $signed(rd_coord);
		scan_end = CW'(idx_q) == (n_eff - CW'(3));
		dc = $signed({c1_q[31], c1_q}) - $signed({c0_q[31], c0_q});
		dx = $signed({x_q[31], x_q}) - $signed({c0_q[31], c0_q});
		dv = $signed({v1_q[31], v1_q}) - $signed({v0_q[31], v0_q});
		pa = mstep_q[1] ? ma_q[32:16] : {1'b0, ma_q[15:0]};
		pb = mstep_q[0] ? mb_q[32:16] : {1'b0, mb_q[15:0]};
		acc_sum = acc_q + ({32'b0, pp_q} << sh_q);
		rem_sh  = {rem_q[32:0], dvd_q[64]};
		rem_ge  = rem_sh >= {1'b0, md_q};
		q_big   = (dvd_q[64:34] != '0) || (dvd_q[33] && (dvd_q[32:0] != '0));
		if (neg_q) begin
			s_sum = $signed({{3{v0_q[31]}}, v0_q}) - $signed({1'b0, dvd_q[33:0]});
		end else begin
			s_sum = $signed({{3{v0_q[31]}}, v0_q}) + $signed({1'b0, dvd_q[33:0]});
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pwli_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_word.func == pwli_pkg::FUNC_LOAD) ?
						pwli_pkg::ST_DONE : pwli_pkg::ST_ENDS0;
				end
			end
			pwli_pkg::ST_ENDS0: state_d = pwli_pkg::ST_ENDS1;
			pwli_pkg::ST_ENDS1: state_d = pwli_pkg::ST_DECIDE;
			pwli_pkg::ST_DECIDE: begin
				if (below || above) begin
					state_d = (border_mode_q == pwli_pkg::BORDER_EXTRAP) ?
						pwli_pkg::ST_RD0 : pwli_pkg::ST_DONE;
				end else if (n_eff == CW'(2)) begin
					state_d = pwli_pkg::ST_RD0;
				end else begin
					state_d = pwli_pkg::ST_SCAN;
				end
			end
			pwli_pkg::ST_SCAN: begin
				if (scan_hit || scan_end) begin
					state_d = pwli_pkg::ST_RD0;
				end
			end
			pwli_pkg::ST_RD0: state_d = pwli_pkg::ST_RD1;
			pwli_pkg::ST_RD1: state_d = pwli_pkg::ST_RD2;
			pwli_pkg::ST_RD2: state_d = pwli_pkg::ST_PREP;
			pwli_pkg::ST_PREP: state_d = (dc == '0) ? pwli_pkg::ST_DONE : pwli_pkg::ST_MUL;
			pwli_pkg::ST_MUL: begin
				if (mstep_q == 3'd4) begin
					state_d = pwli_pkg::ST_DIV;
				end
			end
			pwli_pkg::ST_DIV: begin
				if (dcnt_q == 7'd64) begin
					state_d = pwli_pkg::ST_FIN;
				end
			end
			pwli_pkg::ST_FIN: state_d = pwli_pkg::ST_DONE;
			pwli_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pwli_pkg::ST_IDLE;
				end
			end
			default: state_d = pwli_pkg::ST_IDLE;
		endcase
	end

	// Handshake and RAM read address.
	always_comb begin
		in_ready = 1'b0;
		raddr    = '0;
		case (state_q)
			pwli_pkg::ST_IDLE:   in_ready = 1'b1;
			pwli_pkg::ST_ENDS0:  raddr = last_addr;
			pwli_pkg::ST_DECIDE: raddr = AW'(1);
			pwli_pkg::ST_SCAN:   raddr = idx_q + AW'(2);
			pwli_pkg::ST_RD0:    raddr = seg_q;
			pwli_pkg::ST_RD1:    raddr = seg_q + AW'(1);
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwli_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		case (state_q)
			pwli_pkg::ST_IDLE: begin
				x_q   <= in_word.query_x;
				res_q <= '0;
				st_q  <= pwli_pkg::STATUS_OK;
			end
			pwli_pkg::ST_ENDS0: begin
				first_q  <= $signed(rd_coord);
				vfirst_q <= $signed(rd_value);
			end
			pwli_pkg::ST_ENDS1: begin
				last_q  <= $signed(rd_coord);
				vlast_q <= $signed(rd_value);
			end
			pwli_pkg::ST_DECIDE: begin
				idx_q <= '0;
				seg_q <= (below || !above) ? '0 : seg_last;
				if (below || above) begin
					case (border_mode_q)
						pwli_pkg::BORDER_CLAMP: res_q <= below ? vfirst_q : vlast_q;
						pwli_pkg::BORDER_ERROR: st_q  <= pwli_pkg::STATUS_RANGE;
						default: res_q <= '0;
					endcase
				end
			end
			pwli_pkg::ST_SCAN: begin
				if (scan_hit) begin
					seg_q <= idx_q;
				end else if (scan_end) begin
					seg_q <= seg_last;
				end
				idx_q <= idx_q + AW'(1);
			end
			pwli_pkg::ST_RD1: begin
				c0_q <= $signed(rd_coord);
				v0_q <= $signed(rd_value);
			end
			pwli_pkg::ST_RD2: begin
				c1_q <= $signed(rd_coord);
				v1_q <= $signed(rd_value);
			end
			pwli_pkg::ST_PREP: begin
				res_q   <= v0_q;
				ma_q    <= dx[32] ? 33'(-dx) : 33'(dx);
				mb_q    <= dv[32] ? 33'(-dv) : 33'(dv);
				md_q    <= dc[32] ? 33'(-dc) : 33'(dc);
				neg_q   <= dx[32] ^ dv[32] ^ dc[32];
				mstep_q <= '0;
				acc_q   <= '0;
			end
			pwli_pkg::ST_MUL: begin
				// One 17x17 partial product per step, accumulated a step later.
				pp_q <= pa * pb;
				sh_q <= 6'(({5'b0, mstep_q[1]} + {5'b0, mstep_q[0]}) << 4);
				if (mstep_q != 3'd0) begin
					acc_q <= acc_sum;
				end
				mstep_q <= mstep_q + 3'd1;
				dvd_q   <= acc_sum[64:0];
				rem_q   <= '0;
				dcnt_q  <= '0;
			end
			pwli_pkg::ST_DIV: begin
				// Restoring division, one quotient bit per cycle.
				rem_q  <= rem_ge ? (rem_sh - {1'b0, md_q}) : rem_sh;
				dvd_q  <= {dvd_q[63:0], rem_ge};
				dcnt_q <= dcnt_q + 7'd1;
			end
			pwli_pkg::ST_FIN: begin
				if (q_big) begin
					st_q  <= pwli_pkg::STATUS_SAT;
					res_q <= neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
				end else if (s_sum > 35'sd2147483647) begin
					st_q  <= pwli_pkg::STATUS_SAT;
					res_q <= 32'sh7fff_ffff;
				end else if (s_sum < -35'sd2147483648) begin
					st_q  <= pwli_pkg::STATUS_SAT;
					res_q <= 32'sh8000_0000;
				end else begin
					res_q <= s_sum[31:0];
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pwli_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pwli_pkg::ST_DONE && out_free) begin
			out_q.result_value <= res_q;
			out_q.status       <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// File: sim/tb_piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator: testbench for the interpolation table
// Loads knot tables, sets border modes and knot counts, and sends queries
// with random idling on both channels. A behavioral predictor computes each
// expected result word, and a checker compares every result field by field.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 256;
	localparam int STALL_LIMIT = 5000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	pwli_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_ready;
	pwli_pkg::out_word_t out_word;
	logic                cfg_we;
	logic                cfg_index;
	logic [8:0]          cfg_wdata;

	// Predictor state: its own copy of the knot table and the registers.
	logic signed [31:0] tab_coord [TABLE_DEPTH];
	logic signed [31:0] tab_value [TABLE_DEPTH];
	logic [1:0]         pred_mode;
	logic [8:0]         pred_count;

	pwli_pkg::out_word_t expected_q[$];
	int        error_count;
	int        stall_cycles;
	int        items_sent;
	bit        idle_on;
	int        hold_cycles;

	piecewise_linear_interpolator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Value on segment i at x, saturated to 32 bits.
	function automatic longint segment_value(input int i, input longint x, inout bit sat);
		longint c0, c1, v0, v1, dc, dx, dv, s;
		longint unsigned q;
		bit neg;
		c0 = tab_coord[i];
		c1 = tab_coord[i + 1];
		v0 = tab_value[i];
		v1 = tab_value[i + 1];
		dc = c1 - c0;
		dx = x - c0;
		dv = v1 - v0;
		if (dc == 0) return v0;
		neg = ((dx < 0) != (dv < 0)) != (dc < 0);
		q = (magnitude(dx) * magnitude(dv)) / magnitude(dc);
		if (q > (64'd1 << 33)) begin
			sat = 1'b1;
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		end
		s = neg ? v0 - longint'(q) : v0 + longint'(q);
		if (s > 64'sd2147483647 || s < -64'sd2147483648) sat = 1'b1;
		return clip32(s);
	endfunction

	// Expected result of one word; a load updates the predictor's table.
	function automatic pwli_pkg::out_word_t interpolated_word(input pwli_pkg::in_word_t w);
		pwli_pkg::out_word_t o;
		int n, i;
		longint x, first, last, r;
		bit sat;
		o.result_value = '0;
		o.status = pwli_pkg::STATUS_OK;
		sat = 1'b0;
		r = 0;
		if (w.func == pwli_pkg::FUNC_LOAD) begin
			tab_coord[w.knot_index] = w.knot_coord;
			tab_value[w.knot_index] = w.knot_value;
			return o;
		end
		n = (pred_count < 2) ? 2 : (pred_count > TABLE_DEPTH) ? TABLE_DEPTH : pred_count;
		x = w.query_x;
		first = tab_coord[0];
		last = tab_coord[n - 1];
		if (x < first || x > last) begin
			case (pred_mode)
				pwli_pkg::BORDER_ZERO: r = 0;
				pwli_pkg::BORDER_CLAMP: r = (x < first) ? tab_value[0] : tab_value[n - 1];
				pwli_pkg::BORDER_EXTRAP: r = segment_value((x < first) ? 0 : n - 2, x, sat);
				default: begin
					r = 0;
					o.status = pwli_pkg::STATUS_RANGE;
				end
			endcase
		end else begin
			for (i = 0; i < n - 2; i++)
				if (x < longint'(tab_coord[i + 1])) break;
			r = segment_value(i, x, sat);
		end
		if (sat) o.status = pwli_pkg::STATUS_SAT;
		o.result_value = r[31:0];
		return o;
	endfunction

	// Receiver: random back-pressure, or a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else begin
				out_ready = idle_on ? ($urandom_range(99) >= 32) : 1'b1;
			end
		end
	end

	// Result checker: compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with no expectation: value %0d status %0d",
					out_word.result_value, out_word.status);
				error_count++;
			end else begin
				pwli_pkg::out_word_t e;
				e = expected_q.pop_front();
				if (out_word.result_value !== e.result_value) begin
					$error("result_value: expected %0d, actual %0d",
						e.result_value, out_word.result_value);
					error_count++;
				end
				if (out_word.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, out_word.status);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one word and wait until the block takes it.
	task automatic send_word(input pwli_pkg::in_word_t w);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 32) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		in_word = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(interpolated_word(w));
		items_sent++;
	endtask

	task automatic load_knot(input int idx, input logic signed [31:0] c,
			input logic signed [31:0] v);
		pwli_pkg::in_word_t w;
		w.func = pwli_pkg::FUNC_LOAD;
		w.knot_index = idx[7:0];
		w.knot_coord = c;
		w.knot_value = v;
		w.query_x = $urandom;
		send_word(w);
	endtask

	task automatic query_at(input logic signed [31:0] x);
		pwli_pkg::in_word_t w;
		w.func = pwli_pkg::FUNC_QUERY;
		w.knot_index = 8'($urandom);
		w.knot_coord = $urandom;
		w.knot_value = $urandom;
		w.query_x = x;
		send_word(w);
	endtask

	// Stop offering and wait until every expected result word has come.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (expected_q.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] data);
		drain();
		cfg_index = idx;
		cfg_wdata = data;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == pwli_pkg::REG_BORDER_MODE) pred_mode = data[1:0];
		else pred_count = data;
	endtask

	// Directed: extremes of the fields, every border mode, saturation,
	// a query on the last knot and a zero-width segment.
	task automatic test_directed();
		logic [1:0] m;
		write_reg(pwli_pkg::REG_KNOT_COUNT, 9'd4);
		load_knot(0, 32'sh80000000, 32'sh7FFFFFFF);
		load_knot(1, 32'sh00000000, 32'sh80000000);
		load_knot(2, 32'sh00010000, 32'sh00010000);
		load_knot(3, 32'sh7FFFFFFF, 32'sh00000000);
		query_at(32'sh80000000);
		query_at(32'sh7FFFFFFF);
		query_at(32'sh00000000);
		query_at(32'sh00008000);
		query_at(32'shC0000000);
		// Narrow table with a zero-width middle segment, steep end segments.
		load_knot(0, -32'sh00010000, 32'sh7FFFFFFF);
		load_knot(1, 32'sh00000000, 32'sh80000000);
		load_knot(2, 32'sh00000000, 32'sh00050000);
		load_knot(3, 32'sh00020000, -32'sh00030000);
		for (int k = 0; k < 4; k++) begin
			m = k[1:0];
			write_reg(pwli_pkg::REG_BORDER_MODE, {7'b0, m});
			query_at(32'sh80000000);
			query_at(32'sh7FFFFFFF);
			query_at(32'sh00020000);
		end
		query_at(32'sh00000000);
		// Knot count below the minimum acts as two knots.
		write_reg(pwli_pkg::REG_KNOT_COUNT, 9'd0);
		query_at(-32'sh00008000);
		write_reg(pwli_pkg::REG_KNOT_COUNT, 9'd1);
		query_at(32'sh7FFFFFFF);
	endtask

	// Full table, knot count above the maximum, and a long receiver hold-off.
	task automatic test_full_table();
		for (int k = 0; k < TABLE_DEPTH; k++)
			load_knot(k, (k - 128) * 32'sh00100000 + 32'sh1234,
				$urandom_range(0, 32'h000FFFFF) - 32'sh00080000);
		write_reg(pwli_pkg::REG_KNOT_COUNT, 9'd511);
		write_reg(pwli_pkg::REG_BORDER_MODE, {7'b0, pwli_pkg::BORDER_EXTRAP});
		query_at(32'sh7FFFFFFF);
		query_at(32'sh7F000000);
		write_reg(pwli_pkg::REG_KNOT_COUNT, 9'd256);
		hold_cycles = 400;
		for (int k = 0; k < 12; k++) begin
			if (k % 3 == 0) query_at($urandom);
			else load_knot(k + 240, (k + 112) * 32'sh00100000 + 32'sh1234, $urandom);
		end
		drain();
	endtask

	// Random phases: a fresh table per phase, then mixed loads and queries.
	task automatic test_random();
		int n, mode_pick;
		longint cur, room, step, first, last, span, xl;
		logic signed [31:0] x;
		while (items_sent < 1070) begin
			idle_on = ($urandom_range(9) != 0);
			n = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
			mode_pick = $urandom_range(3);
			write_reg(pwli_pkg::REG_BORDER_MODE, {7'b0, mode_pick[1:0]});
			write_reg(pwli_pkg::REG_KNOT_COUNT, n[8:0]);
			cur = $signed(32'($urandom_range(0, 32'hFFFFFFFF)));
			if ($urandom_range(1)) cur = cur >>> $urandom_range(1, 12);
			if (cur > 0) cur = -cur;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(15) == 0) begin
					load_knot(k, $urandom, $urandom);
				end else begin
					load_knot(k, clip32(cur), ($urandom_range(3) == 0) ?
						32'($signed(32'($urandom)) >>> 12) : 32'($urandom));
				end
				room = (64'sd2147483647 - cur) / (n - k);
				step = ($urandom_range(11) == 0 || room < 1) ? 0 :
					longint'($urandom_range(1, (room > 32'h7FFFFFFF) ?
						32'h7FFFFFFF : room[31:0]));
				cur = cur + step;
			end
			first = tab_coord[0];
			last = tab_coord[n - 1];
			span = (last > first) ? last - first : 64'd65536;
			for (int k = 0; k < 2 * n + 10; k++) begin
				case ($urandom_range(7))
					0: load_knot($urandom_range(255), $urandom, $urandom);
					1: query_at(tab_coord[$urandom_range(n - 1)]);
					2: query_at($urandom);
					default: begin
						xl = first - span / 4 + longint'($urandom_range(0,
							(span * 3 / 2 > 32'hFFFFFFFF) ? 32'hFFFFFFFF :
							32'(span * 3 / 2)));
						x = clip32(xl);
						query_at(x);
					end
				endcase
			end
		end
		drain();
	endtask

	// Sequence of tests.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = pwli_pkg::REG_BORDER_MODE;
		cfg_wdata = '0;
		error_count = 0;
		stall_cycles = 0;
		items_sent = 0;
		idle_on = 1'b1;
		hold_cycles = 0;
		pred_mode = pwli_pkg::BORDER_ZERO;
		pred_count = 9'd2;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			tab_coord[k] = '0;
			tab_value[k] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_random();

		drain();
		repeat (100) @(negedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected result words never arrived", expected_q.size());
			error_count++;
		end
		if (error_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
